// File: design/gdn_pkg.sv
// Shared types, constants and month tables for the Gregorian date to day number unit.
// Used by every module in the design folder; depends on nothing else.
package gdn_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned Y_W     = 14;  // years past the base year
  localparam int unsigned V_W     = 15;  // y + 99, numerator for the ceiling by 100
  localparam int unsigned PROD_W  = 25;  // V_W x 10-bit reciprocal
  localparam int unsigned Q_W     = 9;   // quotient estimate taken from the product
  localparam int unsigned C4_W    = 12;
  localparam int unsigned C100_W  = 8;
  localparam int unsigned C400_W  = 7;
  localparam int unsigned LEAPS_W = 12;
  localparam int unsigned MS_W    = 9;
  localparam int unsigned TOT_W   = 23;  // full count; weekdays use a 16-bit sum
  localparam int unsigned CNT_W   = 22;
  localparam int unsigned WD_W    = 3;
  localparam int unsigned W16     = 16;

  localparam logic [YEAR_W-1:0] BaseYear    = 14'd2000;
  localparam logic [YEAR_W-1:0] MaxYear     = 14'd9999;
  localparam logic [9:0]        Recip100    = 10'd655;  // 655 / 2^16 just below 1/100
  localparam int unsigned       RecipShift  = 16;
  localparam logic [6:0]        Hundred     = 7'd100;
  localparam logic [8:0]        DaysPerYear = 9'd365;
  localparam logic [2:0]        BaseWeekday = 3'd6;     // 1 Jan 2000 was a Saturday
  localparam logic [DAY_W-1:0]  FebLeapDays = 5'd29;

  localparam logic [MONTH_W-1:0] MonthFeb = 4'd2;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  // stage 1 -> stage 2
  typedef struct packed {
    logic              err;
    logic [Y_W-1:0]    y;
    logic [V_W-1:0]    v;
    logic [PROD_W-1:0] prod;
    logic [C4_W-1:0]   c4;
    logic [MS_W-1:0]   ms;
    logic [DAY_W-1:0]  mlen;
    logic              is_feb;
    logic              after_feb;
    logic [DAY_W-1:0]  day;
  } dec_t;

  // stage 3 -> stage 4
  typedef struct packed {
    logic               err;
    logic [Y_W-1:0]     y;
    logic [TOT_W-1:0]   y365;
    logic [LEAPS_W-1:0] leaps;
    logic [MS_W-1:0]    ms;
    logic               adj;
    logic [DAY_W-1:0]   day;
    logic [DAY_W-1:0]   mdays;
    logic               leap;
  } lp_t;

  typedef struct packed {
    logic [CNT_W-1:0] day_count;
    logic [WD_W-1:0]  weekday;
    logic [WD_W-1:0]  first_dow;
    logic [DAY_W-1:0] month_days;
    logic             leap_year;
    logic             error;
  } res_t;

  function automatic logic [MS_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [MS_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // zero length marks a month number that means nothing
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      4'd2:                                        r = 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

  // 8 is 1 mod 7: fold octal digits twice, then one compare and subtract
  function automatic logic [WD_W-1:0] mod7(input logic [W16-1:0] x);
    logic [5:0] a;
    logic [3:0] b;
    a = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
    b = 4'(a[2:0]) + 4'(a[5:3]);
    if (b >= 4'd7) begin
      b = b - 4'd7;
    end
    return b[2:0];
  endfunction

endpackage

// File: design/gregorian_date_to_day_number_unit.sv
// Gregorian date to day number: takes one date (year, month, day) per transaction and
// returns days since 1 Jan 2000, the weekday (0 Sunday), the weekday of the 1st of that
// month, the month length and a leap flag. Years 2000..9999, months 1..12 and days within
// the month are valid; anything else returns all fields zero with tuser (error) high.
// Five register stages, one date per cycle while m_axis_tready_i is high; the leap count
// uses a reciprocal multiply for the division by 100. Holds no state; no clearing pass.
// Depends on gdn_pkg, gdn_decode, gdn_leap and gdn_count.
module gregorian_date_to_day_number_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [13:0] year, [17:14] month, [22:18] day, [23] zero
  input  logic [gdn_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [21:0] day_count, [24:22] weekday, [27:25] first_dow, [32:28] month_days,
  // [33] leap_year, [39:34] zero
  output logic [gdn_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // [0] error
  output logic                              m_axis_tuser_o
);

  logic          dec_valid, dec_ready;
  gdn_pkg::dec_t dec;
  logic          lp_valid, lp_ready;
  gdn_pkg::lp_t  lp;
  gdn_pkg::res_t res;

  gdn_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .year_i      (s_axis_tdata_i[13:0]),
    .month_i     (s_axis_tdata_i[17:14]),
    .day_i       (s_axis_tdata_i[22:18]),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_o       (dec)
  );

  gdn_leap u_leap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_i        (dec),
    .out_valid_o (lp_valid),
    .out_ready_i (lp_ready),
    .out_o       (lp)
  );

  gdn_count u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lp_valid),
    .in_ready_o  (lp_ready),
    .in_i        (lp),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {6'b0, res.leap_year, res.month_days, res.first_dow,
                           res.weekday, res.day_count};
  assign m_axis_tuser_o = res.error;

endmodule

// File: design/gdn_decode.sv
// Stage 1: range checks, month table look-up, quarter count and the reciprocal product
// for the ceiling by 100. Depends on gdn_pkg.
module gdn_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [gdn_pkg::YEAR_W-1:0]  year_i,
  input  logic [gdn_pkg::MONTH_W-1:0] month_i,
  input  logic [gdn_pkg::DAY_W-1:0]   day_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output gdn_pkg::dec_t              out_o
);

  logic          valid_q;
  logic          load;
  gdn_pkg::dec_t dec_d, dec_q;
  logic [gdn_pkg::Y_W:0] c4_sum;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_ready_o && in_valid_i;

  always_comb begin
    dec_d.err = (year_i < gdn_pkg::BaseYear) || (year_i > gdn_pkg::MaxYear)
             || (gdn_pkg::month_len(month_i) == '0);
    dec_d.y    = year_i - gdn_pkg::BaseYear;
    dec_d.v    = gdn_pkg::V_W'(dec_d.y) + gdn_pkg::V_W'(99);
    dec_d.prod = gdn_pkg::PROD_W'(dec_d.v) * gdn_pkg::PROD_W'(gdn_pkg::Recip100);
    // years in [2000, year-1] that are multiples of 4: ceil(y / 4)
    c4_sum     = (gdn_pkg::Y_W + 1)'(dec_d.y) + (gdn_pkg::Y_W + 1)'(3);
    dec_d.c4   = c4_sum[gdn_pkg::C4_W+1:2];
    dec_d.ms        = gdn_pkg::month_start(month_i);
    dec_d.mlen      = gdn_pkg::month_len(month_i);
    dec_d.is_feb    = (month_i == gdn_pkg::MonthFeb);
    dec_d.after_feb = (month_i > gdn_pkg::MonthFeb);
    dec_d.day       = day_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dec_q <= dec_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = dec_q;

endmodule

// File: design/gdn_leap.sv
// Stages 2 and 3: finish the ceiling by 100, scale years by 365, then the leap flag,
// leap count, month length and day check. Depends on gdn_pkg.
module gdn_leap (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gdn_pkg::dec_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gdn_pkg::lp_t  out_o
);

  typedef struct packed {
    logic                        err;
    logic [gdn_pkg::Y_W-1:0]     y;
    logic [gdn_pkg::TOT_W-1:0]   y365;
    logic [gdn_pkg::C4_W-1:0]    c4;
    logic [gdn_pkg::C100_W-1:0]  c100;
    logic [gdn_pkg::MS_W-1:0]    ms;
    logic [gdn_pkg::DAY_W-1:0]   mlen;
    logic                        is_feb;
    logic                        after_feb;
    logic [gdn_pkg::DAY_W-1:0]   day;
  } mid_t;

  logic         va_q, vb_q;
  logic         rdy_a, rdy_b;
  mid_t         a_d, a_q;
  gdn_pkg::lp_t b_d, b_q;

  logic [gdn_pkg::Q_W-1:0]  q_est;
  logic [gdn_pkg::W16-1:0]  rem;
  logic [gdn_pkg::V_W-1:0]  hund_mul;
  logic [gdn_pkg::Q_W-1:0]  c400_sum;
  logic [gdn_pkg::C400_W-1:0] c400;
  logic                     div4, div100, div400;

  assign rdy_b      = !vb_q || out_ready_i;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  // stage 2: quotient estimate is low by at most one
  always_comb begin
    q_est = in_i.prod[gdn_pkg::PROD_W-1:gdn_pkg::RecipShift];
    rem   = gdn_pkg::W16'(in_i.v)
          - gdn_pkg::W16'(q_est) * gdn_pkg::W16'(gdn_pkg::Hundred);
    a_d.err       = in_i.err;
    a_d.y         = in_i.y;
    a_d.y365      = gdn_pkg::TOT_W'(in_i.y) * gdn_pkg::TOT_W'(gdn_pkg::DaysPerYear);
    a_d.c4        = in_i.c4;
    a_d.c100      = gdn_pkg::C100_W'(q_est + ((rem >= gdn_pkg::W16'(gdn_pkg::Hundred)) ?
                    gdn_pkg::Q_W'(1) : gdn_pkg::Q_W'(0)));
    a_d.ms        = in_i.ms;
    a_d.mlen      = in_i.mlen;
    a_d.is_feb    = in_i.is_feb;
    a_d.after_feb = in_i.after_feb;
    a_d.day       = in_i.day;
  end

  // stage 3: base year is a multiple of 400, so divisibility of y decides the leap rule
  always_comb begin
    hund_mul = gdn_pkg::V_W'(a_q.c100) * gdn_pkg::V_W'(gdn_pkg::Hundred);
    div4     = (a_q.y[1:0] == 2'b00);
    div100   = (hund_mul == gdn_pkg::V_W'(a_q.y));
    div400   = div100 && (a_q.c100[1:0] == 2'b00);
    c400_sum = gdn_pkg::Q_W'(a_q.c100) + gdn_pkg::Q_W'(3);
    c400     = c400_sum[gdn_pkg::Q_W-1:2];
    b_d.leap  = div4 && (!div100 || div400);
    b_d.leaps = a_q.c4 - gdn_pkg::LEAPS_W'(a_q.c100) + gdn_pkg::LEAPS_W'(c400);
    b_d.mdays = (a_q.is_feb && b_d.leap) ? gdn_pkg::FebLeapDays : a_q.mlen;
    b_d.err   = a_q.err || (a_q.day == '0) || (a_q.day > b_d.mdays);
    b_d.y     = a_q.y;
    b_d.y365  = a_q.y365;
    b_d.ms    = a_q.ms;
    b_d.adj   = b_d.leap && a_q.after_feb;
    b_d.day   = a_q.day;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_q <= a_d;
    end
    if (rdy_b && va_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = vb_q;
  assign out_o       = b_q;

endmodule

// File: design/gdn_count.sv
// Stages 4 and 5: first-of-month count and its weekday, then the date's count, weekday
// and the output register with zeroing on error. Depends on gdn_pkg.
module gdn_count (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gdn_pkg::lp_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gdn_pkg::res_t out_o
);

  typedef struct packed {
    logic                       err;
    logic [gdn_pkg::TOT_W-1:0]  first;
    logic [gdn_pkg::WD_W-1:0]   wf;
    logic [gdn_pkg::DAY_W-1:0]  day;
    logic [gdn_pkg::DAY_W-1:0]  mdays;
    logic                       leap;
  } fst_t;

  logic          va_q, vb_q;
  logic          rdy_a, rdy_b;
  fst_t          a_d, a_q;
  gdn_pkg::res_t b_d, b_q;
  logic [gdn_pkg::TOT_W-1:0] total;
  logic [gdn_pkg::W16-1:0]   wsum;

  assign rdy_b      = !vb_q || out_ready_i;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  // 365 is 1 mod 7, so the weekday needs only the narrow sum
  always_comb begin
    a_d.first = in_i.y365 + gdn_pkg::TOT_W'(in_i.leaps) + gdn_pkg::TOT_W'(in_i.ms)
              + gdn_pkg::TOT_W'(in_i.adj);
    wsum      = gdn_pkg::W16'(in_i.y) + gdn_pkg::W16'(in_i.leaps) + gdn_pkg::W16'(in_i.ms)
              + gdn_pkg::W16'(in_i.adj) + gdn_pkg::W16'(gdn_pkg::BaseWeekday);
    a_d.wf    = gdn_pkg::mod7(wsum);
    a_d.err   = in_i.err;
    a_d.day   = in_i.day;
    a_d.mdays = in_i.mdays;
    a_d.leap  = in_i.leap;
  end

  always_comb begin
    total = a_q.first + gdn_pkg::TOT_W'(a_q.day) - gdn_pkg::TOT_W'(1);
    b_d   = '0;
    b_d.error = a_q.err;
    if (!a_q.err) begin
      b_d.day_count     = total[gdn_pkg::CNT_W-1:0];
      b_d.weekday       = gdn_pkg::mod7(gdn_pkg::W16'(a_q.wf) + gdn_pkg::W16'(a_q.day)
                        - gdn_pkg::W16'(1));
      b_d.first_dow     = a_q.wf;
      b_d.month_days    = a_q.mdays;
      b_d.leap_year     = a_q.leap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_q <= a_d;
    end
    if (rdy_b && va_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = vb_q;
  assign out_o       = b_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && b_q.error |-> (b_q.day_count == '0) && (b_q.weekday == '0)
      && (b_q.first_dow == '0) && (b_q.month_days == '0) && !b_q.leap_year)
    else $error("error transaction carries non-zero fields");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> (b_q.weekday <= 3'd6) && (b_q.first_dow <= 3'd6))
    else $error("weekday out of range");

  a_mdays_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && !b_q.error |-> (b_q.month_days >= 5'd28) && (b_q.month_days <= 5'd31))
    else $error("month length out of range on a good date");

  a_leap_feb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && !b_q.error && (b_q.month_days == 5'd29) |-> b_q.leap_year)
    else $error("29-day month in a common year");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for gregorian_date_to_day_number_unit: streams dates through
// the block and checks every result against an in-bench calendar predictor.
// Depends on gdn_pkg and the design folder; stands alone otherwise.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned FirstYear = 2000;
  localparam int unsigned LastYear  = 9999;
  localparam int unsigned LeapsTo1999 = 484;

  typedef struct packed {
    logic [gdn_pkg::CNT_W-1:0] day_count;
    logic [gdn_pkg::WD_W-1:0]  weekday;
    logic [gdn_pkg::WD_W-1:0]  first_dow;
    logic [gdn_pkg::DAY_W-1:0] month_days;
    logic                      leap_year;
    logic                      error;
  } date_facts_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [gdn_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [gdn_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tuser;

  logic [gdn_pkg::IN_TDATA_W-1:0] pending_dates[$];
  date_facts_t                    expected_facts[$];
  int unsigned                    mismatches = 0;

  gregorian_date_to_day_number_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [13:0] year, [17:14] month, [22:18] day, [23] zero
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    // [21:0] day_count, [24:22] weekday, [27:25] first_dow, [32:28] month_days,
    // [33] leap_year, [39:34] zero
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)    // [0] error
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- calendar predictor
  function automatic bit is_leap(input int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int unsigned days_before_month(input int unsigned m);
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 1; k < m; k++) begin
      acc += month_length(1, k);
    end
    return acc;
  endfunction

  function automatic int unsigned leaps_through(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic date_facts_t predict_date_facts(
    input logic [gdn_pkg::IN_TDATA_W-1:0] date);
    date_facts_t f;
    int unsigned y, m, d, mlen, first, total;
    bit          lp;
    y = date[13:0];
    m = date[17:14];
    d = date[22:18];
    f = '0;
    if (y < FirstYear || y > LastYear || m < 1 || m > 12) begin
      f.error = 1'b1;
      return f;
    end
    lp = is_leap(y);
    mlen = month_length(y, m);
    if (d < 1 || d > mlen) begin
      f.error = 1'b1;
      return f;
    end
    first = 365 * (y - FirstYear) + (leaps_through(y - 1) - LeapsTo1999)
          + days_before_month(m) + ((lp && m > 2) ? 1 : 0);
    total = first + d - 1;
    f.day_count     = gdn_pkg::CNT_W'(total);
    f.weekday       = gdn_pkg::WD_W'((total + 6) % 7);
    f.first_dow     = gdn_pkg::WD_W'((first + 6) % 7);
    f.month_days    = gdn_pkg::DAY_W'(mlen);
    f.leap_year     = lp;
    return f;
  endfunction

  function automatic logic [gdn_pkg::IN_TDATA_W-1:0] pack_date(input int unsigned y,
                                                               input int unsigned m,
                                                               input int unsigned d);
    return {1'b0, 5'(d), 4'(m), 14'(y)};
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin : fill_dates
    int unsigned y, m, d, mlen, pick;
    // field extremes and range edges
    pending_dates.push_back(pack_date(2000, 1, 1));
    pending_dates.push_back(pack_date(9999, 12, 31));
    pending_dates.push_back(pack_date(1999, 12, 31));
    pending_dates.push_back(pack_date(10000, 1, 1));
    pending_dates.push_back(pack_date(16383, 15, 31));
    pending_dates.push_back(pack_date(0, 0, 0));
    pending_dates.push_back(pack_date(2024, 0, 10));
    pending_dates.push_back(pack_date(2024, 13, 10));
    pending_dates.push_back(pack_date(2024, 15, 10));
    pending_dates.push_back(pack_date(2024, 5, 0));
    pending_dates.push_back(pack_date(2024, 4, 31));
    // leap rule around February
    pending_dates.push_back(pack_date(2000, 2, 29));
    pending_dates.push_back(pack_date(2100, 2, 29));
    pending_dates.push_back(pack_date(2100, 2, 28));
    pending_dates.push_back(pack_date(2400, 2, 29));
    pending_dates.push_back(pack_date(2023, 2, 29));
    pending_dates.push_back(pack_date(2024, 2, 29));
    pending_dates.push_back(pack_date(2000, 2, 30));
    pending_dates.push_back(pack_date(2000, 3, 1));
    pending_dates.push_back(pack_date(2100, 3, 1));
    pending_dates.push_back(pack_date(2000, 12, 31));
    pending_dates.push_back(pack_date(8191, 7, 15));
    pending_dates.push_back(pack_date(8192, 8, 16));

    repeat (1250) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       y = $urandom_range(0, 1) ? $urandom_range(2000, 2003)
                                          : $urandom_range(9996, 9999);
        1:       y = 2000 + 100 * $urandom_range(0, 79);
        default: y = $urandom_range(FirstYear, LastYear);
      endcase
      m = $urandom_range(1, 12);
      mlen = month_length(y, m);
      d = ($urandom_range(0, 4) == 0) ? mlen : $urandom_range(1, mlen);
      if (pick < 65) begin
        pending_dates.push_back(pack_date(y, m, d));
      end else if (pick < 85) begin
        // break exactly one field of a well-formed date
        case ($urandom_range(0, 3))
          0: y = $urandom_range(0, FirstYear - 1);
          1: y = $urandom_range(LastYear + 1, 16383);
          2: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
          default: d = (mlen < 31 && $urandom_range(0, 1)) ? $urandom_range(mlen + 1, 31) : 0;
        endcase
        pending_dates.push_back(pack_date(y, m, d));
      end else begin
        pending_dates.push_back(gdn_pkg::IN_TDATA_W'($urandom)
                                & {1'b0, {(gdn_pkg::IN_TDATA_W-1){1'b1}}});
      end
    end
  end

  // ---------------------------------------------------------------- reset
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- driver
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_facts.push_back(predict_date_facts(s_tdata));
      end
      // hold the current transaction until it is taken
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_dates.size() > 0) begin
          s_tdata  <= pending_dates.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver stalls
  logic [7:0]  stall_pat = 8'hff;
  int unsigned pat_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_left = $urandom_range(16, 96);
        stall_pat = ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom) | 8'h01);
      end else begin
        pat_left--;
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      m_tready <= stall_pat[0];
    end
  end

  // ---------------------------------------------------------------- monitor
  date_facts_t got_facts;
  date_facts_t want_facts;

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got_facts.day_count     = m_tdata[21:0];
      got_facts.weekday       = m_tdata[24:22];
      got_facts.first_dow     = m_tdata[27:25];
      got_facts.month_days    = m_tdata[32:28];
      got_facts.leap_year     = m_tdata[33];
      got_facts.error         = m_tuser;
      if (expected_facts.size() == 0) begin
        report("result with nothing pending, day_count", got_facts.day_count, 0);
      end else begin
        want_facts = expected_facts.pop_front();
        if (got_facts.day_count != want_facts.day_count)
          report("day_count", got_facts.day_count, want_facts.day_count);
        if (got_facts.weekday != want_facts.weekday)
          report("weekday", got_facts.weekday, want_facts.weekday);
        if (got_facts.first_dow != want_facts.first_dow)
          report("first_dow", got_facts.first_dow, want_facts.first_dow);
        if (got_facts.month_days != want_facts.month_days)
          report("month_days", got_facts.month_days, want_facts.month_days);
        if (got_facts.leap_year != want_facts.leap_year)
          report("leap_year", got_facts.leap_year, want_facts.leap_year);
        if (got_facts.error != want_facts.error)
          report("error", got_facts.error, want_facts.error);
      end
    end
  end

  // ---------------------------------------------------------------- end of run
  initial begin
    @(posedge rst_ni);
    while (pending_dates.size() != 0 || s_tvalid) @(posedge clk_i);
    while (expected_facts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
